[rtl/core/q2r_pkg.sv]
`default_nettype none
package q2r_pkg;
  localparam int FracBitsDefault = 14;
  localparam int FieldWidth = 16;
  localparam int Lanes = 9;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;
endpackage
`default_nettype wire

[rtl/core/q2r_if.sv]
`default_nettype none
interface quat_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface matrix_if;
  logic valid;
  logic ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic zero_norm;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                output ready);
endinterface
`default_nettype wire

[rtl/core/q2r_front.sv]
`default_nettype none
module q2r_front
  import q2r_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault,
  localparam int W = FRAC_BITS + 34
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   in_valid,
  input  wire logic signed [15:0]     x,
  input  wire logic signed [15:0]     y,
  input  wire logic signed [15:0]     z,
  input  wire logic signed [15:0]     w,
  output ctl_t                        ctl,
  output logic [Lanes-1:0][W-1:0]     rem,
  output logic [W-1:0]                den,
  output logic [Lanes-1:0]            neg
);
  logic signed [31:0] pxx, pyy, pzz, pww, pxy, pwz, pwy, pxz, pyz, pwx;
  logic               valid_a;
  logic signed [34:0] n2s;
  logic signed [34:0] num [Lanes];
  logic [Lanes-1:0][W-1:0] rem_next;
  logic [Lanes-1:0]   neg_next;
  logic [33:0]        mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      ctl <= '0;
    end else if (adv) begin
      valid_a <= in_valid;
      ctl.valid <= valid_a;
      ctl.zero <= (n2s == 35'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxx <= 32'(x) * 32'(x);
      pyy <= 32'(y) * 32'(y);
      pzz <= 32'(z) * 32'(z);
      pww <= 32'(w) * 32'(w);
      pxy <= 32'(x) * 32'(y);
      pwz <= 32'(w) * 32'(z);
      pwy <= 32'(w) * 32'(y);
      pxz <= 32'(x) * 32'(z);
      pyz <= 32'(y) * 32'(z);
      pwx <= 32'(w) * 32'(x);
      rem <= rem_next;
      neg <= neg_next;
      den <= W'(n2s[32:0]) << FRAC_BITS;
    end
  end

  always_comb begin
    n2s = 35'(pxx) + 35'(pyy) + 35'(pzz) + 35'(pww);
    num[0] = n2s - ((35'(pyy) + 35'(pzz)) <<< 1);
    num[1] = (35'(pxy) - 35'(pwz)) <<< 1;
    num[2] = (35'(pwy) + 35'(pxz)) <<< 1;
    num[3] = (35'(pxy) + 35'(pwz)) <<< 1;
    num[4] = n2s - ((35'(pxx) + 35'(pzz)) <<< 1);
    num[5] = (35'(pyz) - 35'(pwx)) <<< 1;
    num[6] = (35'(pxz) - 35'(pwy)) <<< 1;
    num[7] = (35'(pwx) + 35'(pyz)) <<< 1;
    num[8] = n2s - ((35'(pxx) + 35'(pyy)) <<< 1);
    mag = '0;
    for (int k = 0; k < Lanes; k++) begin
      neg_next[k] = num[k][34];
      mag = neg_next[k] ? 34'(-num[k]) : num[k][33:0];
      rem_next[k] = (W'(mag) << FRAC_BITS) + W'(n2s[32:1]);
    end
  end
endmodule
`default_nettype wire

[rtl/core/q2r_cell.sv]
`default_nettype none
module q2r_cell
  import q2r_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault,
  localparam int W = FRAC_BITS + 34
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire ctl_t                          ctl_i,
  input  wire logic [Lanes-1:0][W-1:0]       rem_i,
  input  wire logic [W-1:0]                  den_i,
  input  wire logic [Lanes-1:0]              neg_i,
  input  wire logic [Lanes-1:0][FRAC_BITS:0] q_i,
  output ctl_t                               ctl_o,
  output logic [Lanes-1:0][W-1:0]            rem_o,
  output logic [W-1:0]                       den_o,
  output logic [Lanes-1:0]                   neg_o,
  output logic [Lanes-1:0][FRAC_BITS:0]      q_o
);
  logic [Lanes-1:0]        ge;
  logic [Lanes-1:0][W-1:0] rem_next;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      ge[k] = rem_i[k] >= den_i;
      rem_next[k] = (ge[k] ? rem_i[k] - den_i : rem_i[k]) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (adv) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_o <= rem_next;
      den_o <= den_i;
      neg_o <= neg_i;
      for (int k = 0; k < Lanes; k++) begin
        q_o[k] <= {q_i[k][FRAC_BITS-1:0], ge[k]};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/quaternion_to_rotation_matrix_core.sv]
`default_nettype none
// Quaternion to rotation matrix: takes one quaternion (signed Q2.14, need not be
// unit length) per cycle and returns the nine rotation matrix entries, each rounded
// to nearest with FRAC_BITS fractional bits and limited to +-1.0, plus zero_norm,
// which flags an all-zero quaternion and forces the identity matrix. The front end
// registers the products, then the norm and the divider inputs, and a chain of
// FRAC_BITS + 1 divider cells yields one quotient bit per cell for all nine entries.
// Throughput is one request per cycle; the whole pipeline holds while the result
// at its end is not taken.
module quaternion_to_rotation_matrix_core
  import q2r_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  quat_if.sink     quat,
  matrix_if.source mat
);
  localparam int W = FRAC_BITS + 34;
  localparam int Cells = FRAC_BITS + 1;
  localparam int EW = (FRAC_BITS + 2 > FieldWidth) ? FRAC_BITS + 2 : FieldWidth;
  localparam logic [EW-1:0] One = EW'(1) << FRAC_BITS;

  ctl_t                          ctl [Cells+1];
  logic [Lanes-1:0][W-1:0]       rem [Cells+1];
  logic [W-1:0]                  den [Cells+1];
  logic [Lanes-1:0]              neg [Cells+1];
  logic [Lanes-1:0][FRAC_BITS:0] q   [Cells+1];
  logic [Lanes-1:0][15:0]        ent;
  logic                          adv;

  assign adv = !ctl[Cells].valid || mat.ready;
  assign quat.ready = adv;
  assign q[0] = '0;

  q2r_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(quat.valid),
    .x(quat.quat_x), .y(quat.quat_y), .z(quat.quat_z), .w(quat.quat_w),
    .ctl(ctl[0]), .rem(rem[0]), .den(den[0]), .neg(neg[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    q2r_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .ctl_i(ctl[i]), .rem_i(rem[i]), .den_i(den[i]), .neg_i(neg[i]), .q_i(q[i]),
      .ctl_o(ctl[i+1]), .rem_o(rem[i+1]), .den_o(den[i+1]), .neg_o(neg[i+1]),
      .q_o(q[i+1])
    );
  end

  always_comb begin
    logic [EW-1:0] mq;
    mq = '0;
    for (int k = 0; k < Lanes; k++) begin
      mq = (EW'(q[Cells][k]) > One) ? One : EW'(q[Cells][k]);
      if (ctl[Cells].zero) begin
        mq = (k == 0 || k == 4 || k == 8) ? One : '0;
      end else if (neg[Cells][k]) begin
        mq = -mq;
      end
      ent[k] = mq[15:0];
    end
  end

  assign mat.valid = ctl[Cells].valid;
  assign mat.zero_norm = ctl[Cells].zero;
  assign mat.m00 = ent[0];
  assign mat.m01 = ent[1];
  assign mat.m02 = ent[2];
  assign mat.m10 = ent[3];
  assign mat.m11 = ent[4];
  assign mat.m12 = ent[5];
  assign mat.m20 = ent[6];
  assign mat.m21 = ent[7];
  assign mat.m22 = ent[8];

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk) disable iff (rst)
    quat.ready == (!mat.valid || mat.ready)) else $error("ready mismatch");
  a_zero_off: assert property (@(posedge clk) disable iff (rst)
    mat.valid && mat.zero_norm |-> mat.m01 == 16'd0 && mat.m12 == 16'd0 && mat.m20 == 16'd0)
    else $error("zero quaternion off-diagonal not cleared");
  a_zero_diag: assert property (@(posedge clk) disable iff (rst)
    mat.valid && mat.zero_norm |-> mat.m00 == One[15:0] && mat.m22 == One[15:0])
    else $error("zero quaternion diagonal not identity");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    ctl[Cells-1].valid && adv |=> mat.valid) else $error("request lost in chain");
`endif
endmodule
`default_nettype wire
